[rtl/fso_pkg.sv]
// Shared types, codes and constants of the fire/smoke overlay.
`default_nettype none

package fso_pkg;

	// Operation codes of an input beat
	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_PIXEL = 2'd2;

	// Tent stamped around a hotspot and hotspot motion
	localparam int TENT_HALF  = 20;
	localparam int STAMP_LEN  = 2 * TENT_HALF;
	localparam int LINE_MAX   = 255;
	localparam int DRIFT_BIAS = 3;

	// Blend and palette
	localparam int FIRE_SHIFT = 3;
	localparam int PAL_LIMIT  = 32;
	localparam int PAL_MAX    = 31;

	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] hotspot_index;
		logic [8:0] hotspot_column;
		logic [2:0] drift;
		logic [8:0] column;
		logic [7:0] row;
		logic [7:0] video_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] video_out;
		logic [4:0] red;
		logic [4:0] green;
		logic [4:0] blue;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HS_SET,
		ST_HS_RD,
		ST_STAMP,
		ST_STAMP_END,
		ST_PIX_RD,
		ST_PIX_WR
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic clr_en;
		logic hs_set;
		logic hs_rd;
		logic stamp_start;
		logic stamp_step;
		logic hs_move;
		logic pix_rd;
		logic pix_wr;
	} fso_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] in_op;
		logic       in_idx_ok;
		logic       clr_last;
		logic       stamp_last;
		logic       out_free;
	} fso_sts_t;

endpackage

`default_nettype wire

[rtl/fso_ctrl.sv]
// Controller state machine of the fire/smoke overlay.
`default_nettype none

module fso_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fso_pkg::fso_sts_t sts,
	output fso_pkg::fso_cmd_t cmd
);
	import fso_pkg::*;

	ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					unique case (sts.in_op)
						OP_SET:   state_d = sts.in_idx_ok ? ST_HS_SET : ST_IDLE;
						OP_STEP:  state_d = sts.in_idx_ok ? ST_HS_RD : ST_IDLE;
						OP_PIXEL: state_d = ST_PIX_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_HS_SET: begin
				cmd.hs_set = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_HS_RD: begin
				cmd.hs_rd       = 1'b1;
				cmd.stamp_start = 1'b1;
				state_d         = ST_STAMP;
			end
			ST_STAMP: begin
				cmd.stamp_step = 1'b1;
				if (sts.stamp_last) begin
					state_d = ST_STAMP_END;
				end
			end
			ST_STAMP_END: begin
				cmd.hs_move = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_PIX_RD: begin
				cmd.pix_rd = 1'b1;
				state_d    = ST_PIX_WR;
			end
			ST_PIX_WR: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.pix_wr = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// A beat is only taken in idle, never during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> $past(state_q) == ST_IDLE && state_q != ST_CLEAR)
		else $error("beat accepted outside idle");

	// The stamp walk always runs into its finishing cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STAMP && sts.stamp_last) |=> state_q == ST_STAMP_END)
		else $error("stamp walk did not finish");

	// A pixel read is always followed by its write stage
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_rd |=> state_q == ST_PIX_WR)
		else $error("pixel read without write stage");

endmodule

`default_nettype wire

[rtl/fso_datapath.sv]
// Datapath of the fire/smoke overlay: stores, stamp pipeline, blend and output register.
`default_nettype none

module fso_datapath #(
	parameter int WIDTH    = 320,
	parameter int HEIGHT   = 240,
	parameter int HOTSPOTS = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fso_pkg::in_item_t  item,
	input  fso_pkg::fso_cmd_t  cmd,
	output fso_pkg::fso_sts_t  sts,
	input  logic               result_stall,
	output logic               result_valid,
	output fso_pkg::out_item_t result
);
	import fso_pkg::*;

	localparam int CELLS = WIDTH * HEIGHT;
	localparam int CLR_N = (CELLS > HOTSPOTS) ? CELLS : HOTSPOTS;
	localparam int CLR_W = $clog2(CLR_N);
	localparam int FA_W  = $clog2(CELLS);
	localparam int BL_W  = $clog2(WIDTH);
	localparam int HI_W  = (HOTSPOTS > 1) ? $clog2(HOTSPOTS) : 1;
	localparam int HC_W  = ($clog2(WIDTH) > 9) ? $clog2(WIDTH) : 9;
	localparam int HS_W  = HC_W + 2;
	localparam int PA_W  = 20;

	// Stores
	logic [7:0]      fire_mem [CELLS];
	logic [7:0]      bl_mem   [WIDTH];
	logic [HC_W-1:0] hs_mem   [HOTSPOTS];

	in_item_t        item_q;
	logic [CLR_W-1:0] clr_q;
	logic [5:0]      k_q;
	logic [7:0]      fire_rd_q;
	logic [7:0]      bl_rd_q;
	logic [HC_W-1:0] hs_rd_q;
	logic [BL_W-1:0] c_s1;
	logic [4:0]      tent_s1;
	logic            wr_vld_s1;
	logic            result_valid_q;
	out_item_t       result_q;
	logic            st_in;

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	// Clearing pass counter and stamp column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			k_q       <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.stamp_start) begin
				k_q <= '0;
			end else if (cmd.stamp_step) begin
				k_q <= k_q + 1'b1;
			end
			wr_vld_s1 <= 1'b0;
			if (cmd.stamp_step) begin
				wr_vld_s1 <= st_in;
			end
		end
	end

	logic clr_fire, clr_bl, clr_hs;
	assign clr_fire = cmd.clr_en && ({1'b0, clr_q} < (CLR_W + 1)'(CELLS));
	assign clr_bl   = cmd.clr_en && ({1'b0, clr_q} < (CLR_W + 1)'(WIDTH));
	assign clr_hs   = cmd.clr_en && ({1'b0, clr_q} < (CLR_W + 1)'(HOTSPOTS));

	// Pixel position decode
	logic [PA_W-1:0] pix_base, pix_below;
	logic            pix_in, pix_bottom;
	assign pix_base   = PA_W'(item_q.row) * PA_W'(WIDTH) + PA_W'(item_q.column);
	assign pix_below  = pix_base + PA_W'(WIDTH);
	assign pix_in     = ({2'b0, item_q.column} < 11'(WIDTH)) && ({3'b0, item_q.row} < 11'(HEIGHT));
	assign pix_bottom = {3'b0, item_q.row} == 11'(HEIGHT - 1);

	// Stamp column, in range check and tent height
	logic [HS_W-1:0] st_sum, st_col;
	logic [4:0]      tent;
	assign st_sum = HS_W'(hs_rd_q) + HS_W'(k_q);
	assign st_col = st_sum - HS_W'(TENT_HALF);
	assign st_in  = (st_sum >= HS_W'(TENT_HALF)) && (st_col < HS_W'(WIDTH));
	assign tent   = (k_q <= 6'(TENT_HALF)) ? 5'(k_q) : 5'(6'(STAMP_LEN) - k_q);

	always_ff @(posedge clk) begin
		if (cmd.stamp_step) begin
			c_s1    <= st_col[BL_W-1:0];
			tent_s1 <= tent;
		end
	end

	// Saturating add of the tent into the line entry
	logic [8:0] sat_sum;
	logic [7:0] sat_val;
	assign sat_sum = {1'b0, bl_rd_q} + 9'(tent_s1);
	assign sat_val = (sat_sum > 9'(LINE_MAX)) ? 8'(LINE_MAX) : sat_sum[7:0];

	// New hotspot position, wrapped once around the width
	logic [HS_W-1:0] mv_sum, mv_sub;
	logic [HC_W-1:0] hs_new;
	assign mv_sum = HS_W'(hs_rd_q) + HS_W'(item_q.drift);
	assign mv_sub = mv_sum - HS_W'(DRIFT_BIAS);
	always_comb begin
		if (mv_sum < HS_W'(DRIFT_BIAS)) begin
			hs_new = HC_W'(mv_sum + HS_W'(WIDTH) - HS_W'(DRIFT_BIAS));
		end else if (mv_sub >= HS_W'(WIDTH)) begin
			hs_new = HC_W'(mv_sub - HS_W'(WIDTH));
		end else begin
			hs_new = HC_W'(mv_sub);
		end
	end

	// New fire value of the pixel
	logic [7:0] fire_val;
	always_comb begin
		if (!pix_in) begin
			fire_val = 8'd0;
		end else if (pix_bottom) begin
			fire_val = bl_rd_q;
		end else if (fire_rd_q != 8'd0) begin
			fire_val = fire_rd_q - 8'd1;
		end else begin
			fire_val = 8'd0;
		end
	end

	// Fire store port
	logic            fire_we;
	logic [FA_W-1:0] fire_wa;
	logic [7:0]      fire_wd;
	assign fire_we = clr_fire || (cmd.pix_wr && pix_in);
	assign fire_wa = cmd.clr_en ? clr_q[FA_W-1:0] : pix_base[FA_W-1:0];
	assign fire_wd = cmd.clr_en ? 8'd0 : fire_val;

	always_ff @(posedge clk) begin
		if (fire_we) begin
			fire_mem[fire_wa] <= fire_wd;
		end
		if (cmd.pix_rd) begin
			fire_rd_q <= fire_mem[pix_below[FA_W-1:0]];
		end
	end

	// Bottom line port: clear, stamp write or pixel take
	logic            bl_we;
	logic [BL_W-1:0] bl_wa;
	logic [7:0]      bl_wd;
	assign bl_we = clr_bl || wr_vld_s1 || (cmd.pix_wr && pix_in && pix_bottom);
	always_comb begin
		if (cmd.clr_en) begin
			bl_wa = clr_q[BL_W-1:0];
		end else if (wr_vld_s1) begin
			bl_wa = c_s1;
		end else begin
			bl_wa = BL_W'(item_q.column);
		end
	end
	assign bl_wd = wr_vld_s1 ? sat_val : 8'd0;

	always_ff @(posedge clk) begin
		if (bl_we) begin
			bl_mem[bl_wa] <= bl_wd;
		end
		if (cmd.pix_rd) begin
			bl_rd_q <= bl_mem[BL_W'(item_q.column)];
		end else if (cmd.stamp_step) begin
			bl_rd_q <= bl_mem[st_col[BL_W-1:0]];
		end
	end

	// Hotspot store port
	logic            hs_we;
	logic [HI_W-1:0] hs_wa;
	logic [HC_W-1:0] hs_wd;
	assign hs_we = clr_hs || cmd.hs_set || cmd.hs_move;
	assign hs_wa = cmd.clr_en ? clr_q[HI_W-1:0] : HI_W'(item_q.hotspot_index);
	always_comb begin
		if (cmd.clr_en) begin
			hs_wd = '0;
		end else if (cmd.hs_set) begin
			hs_wd = HC_W'(item_q.hotspot_column);
		end else begin
			hs_wd = hs_new;
		end
	end

	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_mem[hs_wa] <= hs_wd;
		end
		if (cmd.hs_rd) begin
			hs_rd_q <= hs_mem[HI_W'(item_q.hotspot_index)];
		end
	end

	// Blend fire into the video value and map through the palette
	logic [4:0] heat;
	logic [8:0] mix;
	logic [7:0] blend;
	out_item_t  res_d;
	assign heat = 5'(fire_val >> FIRE_SHIFT);
	assign mix  = {1'b0, item_q.video_in} + 9'(heat);
	always_comb begin
		if ({3'b0, heat} > item_q.video_in) begin
			blend = {3'b0, heat};
		end else begin
			blend = 8'(mix >> 1) + 8'd1;
		end
		res_d.video_out = blend;
		if (blend < 8'(PAL_LIMIT)) begin
			res_d.red   = 5'(blend >> 2);
			res_d.green = 5'(blend >> 1);
			res_d.blue  = 5'(blend);
		end else begin
			res_d.red   = 5'(PAL_MAX);
			res_d.green = 5'(PAL_MAX);
			res_d.blue  = 5'(PAL_MAX);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.pix_wr) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_wr) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Status
	assign sts.in_op      = item.operation;
	assign sts.in_idx_ok  = {2'b0, item.hotspot_index} < 9'(HOTSPOTS);
	assign sts.clr_last   = clr_q == CLR_W'(CLR_N - 1);
	assign sts.stamp_last = k_q == 6'(STAMP_LEN - 1);
	assign sts.out_free   = !result_valid_q || !result_stall;

	// A new result never overwrites one still held by the receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_wr |-> !(result_valid_q && result_stall))
		else $error("result overwritten while stalled");

	// A stamp write never shares the line port with a pixel or the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> !(cmd.pix_wr || cmd.clr_en))
		else $error("line store port conflict");

	// The stamp walk stays inside the tent
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stamp_step |-> k_q < 6'(STAMP_LEN))
		else $error("stamp column counter overran");

	// The hotspot moves only after all tent columns were visited
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hs_move |-> k_q == 6'(STAMP_LEN) && $past(cmd.stamp_step))
		else $error("hotspot moved before stamp finished");

endmodule

`default_nettype wire

[rtl/fire_smoke_overlay_core.sv]
// Top level of the fire/smoke overlay: controller, datapath and ports.
//
// Input channel item/item_valid/item_stall takes one operation a beat:
// set hotspot, step hotspot (stamp a tent into the bottom line and move
// the hotspot), or process a pixel. Output channel result/result_valid/
// result_stall returns one beat for each pixel, none for other operations.
// Steps per input beat, from its accept to the next accept:
//   set hotspot: accept, store write
//   step hotspot: accept, hotspot read, 40 tent columns through
//     a read-modify-write on the single line store write port, final write
//   pixel: accept, store reads, store write and result load.
//   bad hotspot index or unused operation: accept only, no effect.
// Each store has one read and one write port; one beat is worked at a time.
// After reset a clearing pass zeroes all stores, one entry a cycle, over
// max(WIDTH*HEIGHT, HOTSPOTS) entries (76800 by default); item_stall stays
// high until it ends. A stalled result is held in the output register; a
// further pixel waits in its write stage until that register frees up.
`default_nettype none

module fire_smoke_overlay_core #(
	parameter int WIDTH    = 320,
	parameter int HEIGHT   = 240,
	parameter int HOTSPOTS = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  fso_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output fso_pkg::out_item_t result
);
	import fso_pkg::*;

	fso_cmd_t cmd;
	fso_sts_t sts;

	fso_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	fso_datapath #(
		.WIDTH    (WIDTH),
		.HEIGHT   (HEIGHT),
		.HOTSPOTS (HOTSPOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the fire/smoke overlay core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fso_pkg::*;

	localparam int SCR_W     = 320;
	localparam int SCR_H     = 240;
	localparam int N_SPOTS   = 80;
	localparam int TENT_PEAK = 20;
	localparam int N_RANDOM  = 500;

	// Operation code that the block leaves unused
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	// Predicted state of the overlay
	bit [7:0] fire_px [0:SCR_W*SCR_H-1];
	bit [7:0] heat_line [0:SCR_W-1];
	int       spot_col [0:N_SPOTS-1];

	out_item_t pending_colors[$];
	int        n_fail;
	int        n_worked;
	bit        calm;

	typedef struct {
		in_item_t  beat;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	dir_row_t plan[$];

	fire_smoke_overlay_core #(
		.WIDTH(SCR_W),
		.HEIGHT(SCR_H),
		.HOTSPOTS(N_SPOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the color beat of one input beat and advance the state
	function automatic void compute_overlay(input in_item_t it, output bit has_px,
			output out_item_t px);
		int h, c, d, v, fire, f, vin, idx;
		has_px = 1'b0;
		px = '0;
		idx = int'(it.hotspot_index);
		case (it.operation)
			OP_SET: begin
				if (idx < N_SPOTS)
					spot_col[idx] = int'(it.hotspot_column);
			end
			OP_STEP: begin
				if (idx < N_SPOTS) begin
					h = spot_col[idx];
					// stamp the tent, clipped to the screen and saturated
					for (c = h - TENT_HALF; c < h + TENT_HALF; c++) begin
						if (c >= 0 && c < SCR_W) begin
							d = (h > c) ? h - c : c - h;
							v = int'(heat_line[c]) + TENT_PEAK - d;
							if (v > LINE_MAX)
								v = LINE_MAX;
							heat_line[c] = 8'(v);
						end
					end
					// move the hotspot, wrapping once
					h += int'(it.drift) - DRIFT_BIAS;
					if (h < 0)
						h += SCR_W;
					else if (h >= SCR_W)
						h -= SCR_W;
					spot_col[idx] = h;
				end
			end
			OP_PIXEL: begin
				fire = 0;
				if (int'(it.column) < SCR_W && int'(it.row) < SCR_H) begin
					if (int'(it.row) == SCR_H - 1) begin
						fire = int'(heat_line[it.column]);
						heat_line[it.column] = 8'd0;
					end else begin
						fire = int'(fire_px[(int'(it.row) + 1) * SCR_W + int'(it.column)]);
						if (fire > 0)
							fire--;
					end
					fire_px[int'(it.row) * SCR_W + int'(it.column)] = 8'(fire);
				end
				// blend with the video and map through the palette
				f = fire >> FIRE_SHIFT;
				vin = int'(it.video_in);
				v = (f > vin) ? f : ((vin + f) >> 1) + 1;
				v = v & 255;
				px.video_out = 8'(v);
				if (v < PAL_LIMIT) begin
					px.red   = 5'(v >> 2);
					px.green = 5'(v >> 1);
					px.blue  = 5'(v);
				end else begin
					px.red   = 5'(PAL_MAX);
					px.green = 5'(PAL_MAX);
					px.blue  = 5'(PAL_MAX);
				end
				has_px = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Mostly short gaps, a few long ones, none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic in_item_t rand_beat();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	task automatic add_row(input logic [1:0] op, input int idx, input int hcol,
			input int drift, input int col, input int row, input int vin,
			input bit typed, input out_item_t want);
		dir_row_t r;
		r.beat.operation      = op;
		r.beat.hotspot_index  = 7'(idx);
		r.beat.hotspot_column = 9'(hcol);
		r.beat.drift          = 3'(drift);
		r.beat.column         = 9'(col);
		r.beat.row            = 8'(row);
		r.beat.video_in       = 8'(vin);
		r.typed = typed;
		r.want  = want;
		plan.push_back(r);
	endtask

	// Drive one input beat and predict its result at the accept edge
	task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t want);
		int        gap;
		bit        has_px;
		out_item_t px;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= beat;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		compute_overlay(beat, has_px, px);
		if (has_px)
			pending_colors.push_back(typed ? want : px);
		if (beat.operation == OP_PIXEL || (beat.operation != OP_UNUSED &&
				int'(beat.hotspot_index) < N_SPOTS))
			n_worked++;
	endtask

	// Stall the result channel in bursts
	initial begin
		int n;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_colors.size() == 0) begin
				$error("result beat %h with no prediction pending", result);
				n_fail++;
			end else begin
				want = pending_colors.pop_front();
				if (result.video_out !== want.video_out) begin
					$error("video_out: expected %0d, got %0d", want.video_out, result.video_out);
					n_fail++;
				end
				if (result.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, result.red);
					n_fail++;
				end
				if (result.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, result.green);
					n_fail++;
				end
				if (result.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, result.blue);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		in_item_t beat;
		int       spot, anchor, left, span, depth;
		n_fail = 0;
		n_worked = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: op, index, hotspot column, drift, column, row, video, typed, want
		add_row(OP_PIXEL, 0, 0, 0, 0, 0, 0, 1, {8'd1, 5'd0, 5'd0, 5'd1});
		add_row(OP_PIXEL, 0, 0, 0, 319, 238, 255, 1, {8'd128, 5'd31, 5'd31, 5'd31});
		add_row(OP_PIXEL, 0, 0, 0, 5, 10, 62, 1, {8'd32, 5'd31, 5'd31, 5'd31});
		add_row(OP_PIXEL, 0, 0, 0, 6, 10, 60, 1, {8'd31, 5'd7, 5'd15, 5'd31});
		add_row(OP_UNUSED, 127, 511, 7, 511, 255, 255, 0, '0);
		add_row(OP_SET, 127, 50, 0, 0, 0, 0, 0, '0);
		add_row(OP_STEP, 80, 0, 5, 0, 0, 0, 0, '0);
		add_row(OP_SET, 79, 0, 0, 0, 0, 0, 0, '0);
		add_row(OP_STEP, 79, 0, 0, 0, 0, 0, 0, '0);
		add_row(OP_PIXEL, 0, 0, 0, 0, 239, 0, 1, {8'd2, 5'd0, 5'd1, 5'd2});
		add_row(OP_PIXEL, 0, 0, 0, 0, 238, 1, 1, {8'd2, 5'd0, 5'd1, 5'd2});
		add_row(OP_PIXEL, 0, 0, 0, 0, 239, 0, 1, {8'd1, 5'd0, 5'd0, 5'd1});
		add_row(OP_STEP, 79, 0, 7, 0, 0, 0, 0, '0);
		add_row(OP_PIXEL, 0, 0, 0, 319, 239, 0, 0, '0);
		add_row(OP_SET, 0, 511, 0, 0, 0, 0, 0, '0);
		add_row(OP_STEP, 0, 0, 7, 0, 0, 0, 0, '0);
		add_row(OP_STEP, 0, 0, 3, 0, 0, 0, 0, '0);
		add_row(OP_SET, 1, 2, 0, 0, 0, 0, 0, '0);
		add_row(OP_STEP, 1, 0, 0, 0, 0, 0, 0, '0);
		add_row(OP_PIXEL, 0, 0, 0, 511, 0, 0, 1, {8'd1, 5'd0, 5'd0, 5'd1});
		add_row(OP_PIXEL, 0, 0, 0, 0, 255, 200, 1, {8'd101, 5'd31, 5'd31, 5'd31});
		add_row(OP_PIXEL, 0, 0, 0, 320, 239, 7, 1, {8'd4, 5'd1, 5'd2, 5'd4});
		add_row(OP_PIXEL, 0, 0, 0, 195, 239, 255, 0, '0);
		add_row(OP_PIXEL, 0, 0, 0, 1, 239, 3, 0, '0);
		foreach (plan[i])
			send_beat(plan[i].beat, plan[i].typed, plan[i].want);

		// Random part: mostly hotspot bursts followed by bottom-up pixel scans
		n_worked = 0;
		while (n_worked < N_RANDOM) begin
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 99) < 65) begin
				spot = $urandom_range(0, N_SPOTS - 1);
				anchor = $urandom_range(0, SCR_W - 1);
				if ($urandom_range(0, 3) != 0) begin
					beat = rand_beat();
					beat.operation = OP_SET;
					beat.hotspot_index = 7'(spot);
					beat.hotspot_column = 9'(anchor);
					send_beat(beat, 1'b0, '0);
				end else begin
					anchor = spot_col[spot];
				end
				// pile heat up around the hotspot, near-still drift mostly
				repeat ($urandom_range(1, 16)) begin
					beat = rand_beat();
					beat.operation = OP_STEP;
					beat.hotspot_index = 7'(spot);
					if ($urandom_range(0, 3) != 0)
						beat.drift = 3'($urandom_range(2, 4));
					send_beat(beat, 1'b0, '0);
				end
				// scan a small window from the bottom row upward
				span = $urandom_range(2, 8);
				depth = $urandom_range(1, 4);
				left = (anchor + SCR_W - $urandom_range(0, 6)) % SCR_W;
				for (int r = 0; r < depth; r++) begin
					for (int j = 0; j < span; j++) begin
						beat = rand_beat();
						beat.operation = OP_PIXEL;
						beat.row = 8'(SCR_H - 1 - r);
						beat.column = 9'((left + j) % SCR_W);
						if ($urandom_range(0, 9) < 7)
							beat.video_in = 8'($urandom_range(0, 40));
						send_beat(beat, 1'b0, '0);
					end
				end
			end else begin
				// noise: any operation with all fields random
				repeat ($urandom_range(1, 6)) begin
					beat = rand_beat();
					send_beat(beat, 1'b0, '0);
				end
			end
		end

		// Drain outstanding results
		item_valid <= 1'b0;
		calm = 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (n_fail == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
rtl/fso_pkg.sv
rtl/fso_ctrl.sv
rtl/fso_datapath.sv
rtl/fire_smoke_overlay_core.sv
tb/sv/testbench.sv
